// ===== rtl/core/tpag_pkg.sv =====
// Shared definitions for the tensor permute address generator.
// Register indexes, field packing constants and parameter defaults.
// No dependencies.
package tpag_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned MAX_DIMS_DEF   = 6;
  localparam int unsigned INDEX_BITS_DEF = 21;

  // Packed register layout: three 21-bit fields per 63-bit register
  localparam int unsigned FIELD_BITS      = 21;
  localparam int unsigned FIELDS_PER_REG  = 3;
  localparam int unsigned CFG_DATA_BITS   = 63;
  localparam int unsigned CFG_INDEX_BITS  = 3;
  localparam int unsigned DIM_CNT_BITS    = 3;
  localparam int unsigned DATA_BITS       = 32;
  localparam int unsigned INT8_BITS       = 8;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_NUM_DIMS     = 3'd0,
    CFG_ELEMENT_TYPE = 3'd1,
    CFG_SHAPE_LOW    = 3'd2,
    CFG_SHAPE_HIGH   = 3'd3,
    CFG_STRIDE_LOW   = 3'd4,
    CFG_STRIDE_HIGH  = 3'd5
  } cfg_reg_e;

  // Element formats
  typedef enum logic {
    ELEM_INT8 = 1'b0,
    ELEM_FP32 = 1'b1
  } elem_type_e;

  // Pick the 21-bit field of dimension k out of a low/high register pair
  function automatic logic [FIELD_BITS-1:0] field_of(
    input logic [CFG_DATA_BITS-1:0] lo,
    input logic [CFG_DATA_BITS-1:0] hi,
    input int unsigned              k
  );
    logic [CFG_DATA_BITS-1:0] word;
    int unsigned              pos;
    word = (k < FIELDS_PER_REG) ? lo : hi;
    pos  = (k < FIELDS_PER_REG) ? k : k - FIELDS_PER_REG;
    return FIELD_BITS'(word >> (pos * FIELD_BITS));
  endfunction

endpackage

// ===== rtl/core/tensor_permute_address_gen.sv =====
// Top level of the tensor permute address generator.
// Uses tpag_pkg for register codes, field layout and defaults.
//
// Registers each input element, taken in row-major order, with its
// destination index in the permuted output tensor for the next cycle. A
// mixed-radix digit counter per dimension (last dimension fastest, dim 0
// never wrapping) walks the input, and a per-dimension product register
// holds digit times output stride, so the index is a sum of up to MAX_DIMS
// registered terms and each step is an add or a clear per dimension.
// Sustained rate is one element per cycle while the consumer takes each
// result and no reload is pending. A write to either stride register
// reloads the product registers from the digit counters through one
// multiplier per dimension; input is held off in the cycle after the write.
// A new beat is taken when the output register is empty or drains; a beat
// with last_in set clears all counters for the next tensor.
module tensor_permute_address_gen #(
  parameter int unsigned MAX_DIMS   = tpag_pkg::MAX_DIMS_DEF,
  parameter int unsigned INDEX_BITS = tpag_pkg::INDEX_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [tpag_pkg::CFG_INDEX_BITS-1:0]  cfg_index_i,
  input  logic [tpag_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  // element input
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [tpag_pkg::DATA_BITS-1:0]       element_data_i,
  input  logic                                 last_in_i,
  // indexed element output
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [INDEX_BITS-1:0]                out_index_o,
  output logic [tpag_pkg::DATA_BITS-1:0]       out_data_o,
  output logic                                 last_out_o
);

  localparam int unsigned FB = tpag_pkg::FIELD_BITS;
  localparam int unsigned DB = tpag_pkg::DIM_CNT_BITS;

  // Configuration registers
  logic [DB-1:0]                      num_dims_q;
  logic                               element_type_q;
  logic [tpag_pkg::CFG_DATA_BITS-1:0] shape_low_q, shape_high_q;
  logic [tpag_pkg::CFG_DATA_BITS-1:0] stride_low_q, stride_high_q;
  logic                               reload_q, reload_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_dims_q     <= DB'(1);
      element_type_q <= 1'b0;
      shape_low_q    <= '0;
      shape_high_q   <= '0;
      stride_low_q   <= '0;
      stride_high_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        tpag_pkg::CFG_NUM_DIMS:     num_dims_q     <= cfg_data_i[DB-1:0];
        tpag_pkg::CFG_ELEMENT_TYPE: element_type_q <= cfg_data_i[0];
        tpag_pkg::CFG_SHAPE_LOW:    shape_low_q    <= cfg_data_i;
        tpag_pkg::CFG_SHAPE_HIGH:   shape_high_q   <= cfg_data_i;
        tpag_pkg::CFG_STRIDE_LOW:   stride_low_q   <= cfg_data_i;
        tpag_pkg::CFG_STRIDE_HIGH:  stride_high_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // New strides: reload the product registers in the following cycle
  always_comb begin
    reload_d = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_index_i) inside
        tpag_pkg::CFG_STRIDE_LOW, tpag_pkg::CFG_STRIDE_HIGH: reload_d = 1'b1;
        default: reload_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reload_q <= 1'b0;
    end else begin
      reload_q <= reload_d;
    end
  end

  // Dimensions in use: zero counts as one, saturate at MAX_DIMS
  logic [DB-1:0] dims_n;
  always_comb begin
    if (num_dims_q == '0) begin
      dims_n = DB'(1);
    end else if (num_dims_q > DB'(MAX_DIMS)) begin
      dims_n = DB'(MAX_DIMS);
    end else begin
      dims_n = num_dims_q;
    end
  end

  // Handshake: output register drains or is empty, and no reload pending
  logic in_fire;
  assign in_ready_o = !reload_q && (!out_valid_o || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;

  // Per-dimension fields, digits and products
  logic [FB-1:0]         size_eff [MAX_DIMS];
  logic [INDEX_BITS-1:0] stride_k [MAX_DIMS];
  logic                  wrap_k   [MAX_DIMS];
  logic [FB-1:0]         digit_q  [MAX_DIMS];
  logic [FB-1:0]         digit_d  [MAX_DIMS];
  logic [INDEX_BITS-1:0] prod_q   [MAX_DIMS];
  logic [INDEX_BITS-1:0] prod_d   [MAX_DIMS];
  logic [INDEX_BITS-1:0] reload_prod [MAX_DIMS];

  for (genvar k = 0; k < MAX_DIMS; k++) begin : g_dim
    logic [FB-1:0]           size_raw;
    logic [FB-1:0]           stride_raw;
    logic [FB:0]             digit_inc;
    logic [2*INDEX_BITS-1:0] mult;

    assign size_raw   = tpag_pkg::field_of(shape_low_q, shape_high_q, k);
    assign stride_raw = tpag_pkg::field_of(stride_low_q, stride_high_q, k);
    assign size_eff[k] = (size_raw == '0) ? FB'(1) : size_raw;
    assign stride_k[k] = stride_raw[INDEX_BITS-1:0];

    // Digit reaches its size on increment
    assign digit_inc = {1'b0, digit_q[k]} + (FB+1)'(1);
    assign wrap_k[k] = digit_inc >= {1'b0, size_eff[k]};

    // Full product for reload, keep the index-width low part
    assign mult = {{INDEX_BITS{1'b0}}, digit_q[k][INDEX_BITS-1:0]}
                * {{INDEX_BITS{1'b0}}, stride_k[k]};
    assign reload_prod[k] = mult[INDEX_BITS-1:0];
  end

  // Counter advance: carry ripples from the fastest dimension in use
  always_comb begin
    logic carry;
    carry = 1'b1;
    for (int k = 0; k < MAX_DIMS; k++) begin
      digit_d[k] = digit_q[k];
      prod_d[k]  = prod_q[k];
    end
    if (reload_q) begin
      for (int k = 0; k < MAX_DIMS; k++) begin
        prod_d[k] = reload_prod[k];
      end
    end else if (in_fire) begin
      if (last_in_i) begin
        for (int k = 0; k < MAX_DIMS; k++) begin
          digit_d[k] = '0;
          prod_d[k]  = '0;
        end
      end else begin
        for (int k = MAX_DIMS - 1; k >= 1; k--) begin
          if (DB'(k) < dims_n && carry) begin
            if (wrap_k[k]) begin
              digit_d[k] = '0;
              prod_d[k]  = '0;
            end else begin
              digit_d[k] = digit_q[k] + FB'(1);
              prod_d[k]  = prod_q[k] + stride_k[k];
              carry      = 1'b0;
            end
          end
        end
        // dim 0 never wraps on size
        if (carry) begin
          digit_d[0] = digit_q[0] + FB'(1);
          prod_d[0]  = prod_q[0] + stride_k[0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_DIMS; k++) begin
        digit_q[k] <= '0;
        prod_q[k]  <= '0;
      end
    end else begin
      for (int k = 0; k < MAX_DIMS; k++) begin
        digit_q[k] <= digit_d[k];
        prod_q[k]  <= prod_d[k];
      end
    end
  end

  // Destination index of the current beat
  logic [INDEX_BITS-1:0] index_sum;
  always_comb begin
    index_sum = '0;
    for (int k = 0; k < MAX_DIMS; k++) begin
      if (DB'(k) < dims_n) begin
        index_sum = index_sum + prod_q[k];
      end
    end
  end

  // Output register
  logic [tpag_pkg::DATA_BITS-1:0] data_masked;
  assign data_masked = (element_type_q == tpag_pkg::ELEM_FP32) ? element_data_i
    : {{(tpag_pkg::DATA_BITS - tpag_pkg::INT8_BITS){1'b0}},
       element_data_i[tpag_pkg::INT8_BITS-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (in_fire) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_index_o <= index_sum;
      out_data_o  <= data_masked;
      last_out_o  <= last_in_i;
    end
  end

endmodule

// ===== rtl/core/tpag_checker.sv =====
// Port-level checks for the tensor permute address generator.
// Uses tpag_pkg; bound to tensor_permute_address_gen below.
module tpag_checker #(
  parameter int unsigned INDEX_BITS = tpag_pkg::INDEX_BITS_DEF
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                cfg_we_i,
  input logic [tpag_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic [INDEX_BITS-1:0]               out_index_o,
  input logic [tpag_pkg::DATA_BITS-1:0]      out_data_o,
  input logic                                last_out_o
);

  // An accepted beat shows up on the output the next cycle
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted beat did not reach the output register");

  // A held result blocks new input
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while output stalled");

  // Stride write holds off input while products reload
  a_stride_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && (cfg_index_i == tpag_pkg::CFG_STRIDE_LOW
              || cfg_index_i == tpag_pkg::CFG_STRIDE_HIGH) |=> !in_ready_o)
    else $error("input accepted during product reload");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_index_o)
      && $stable(out_data_o) && $stable(last_out_o))
    else $error("stalled output beat changed");

endmodule

bind tensor_permute_address_gen tpag_checker #(
  .INDEX_BITS(INDEX_BITS)
) u_tpag_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_we_i    (cfg_we_i),
  .cfg_index_i (cfg_index_i),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_index_o (out_index_o),
  .out_data_o  (out_data_o),
  .last_out_o  (last_out_o)
);
